>>> rtl/jacobi_polynomial_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Jacobi polynomial evaluator assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JACOBI_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define JACOBI_POLYNOMIAL_EVALUATOR_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define JPE_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("jpe check failed");

// Condition in one cycle implies a consequence in the next.
`define JPE_CHECK_NEXT(lbl, ante, cons) `JPE_CHECK(lbl, (ante) |=> (cons))

`endif

>>> rtl/jpe_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi polynomial evaluator package
// Shared widths, constants and beat types.
// ----------------------------------------------------------------------------
`default_nettype none

package jpe_pkg;

	localparam int MAX_ORDER  = 15;
	localparam int MAX_WEIGHT = 15;
	localparam int FRAC_BITS  = 30;

	localparam int XW = 32;       // point width
	localparam int VW = 64;       // value width
	localparam int AW = 2 * VW;   // product accumulator width
	localparam int LW = VW / 2;   // multiplier limb width
	localparam int NW = 4;        // order width
	localparam int IW = 4;        // input weight width
	localparam int WW = 5;        // internal weight width, holds weight + 1
	localparam int KW = 6;        // derivative scale width
	localparam int CW = 24;       // recurrence coefficient width

	localparam int DIV_STEP   = 4;
	localparam int DIV_CYCLES = AW / DIV_STEP;
	localparam int DCW        = $clog2(DIV_CYCLES);

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic signed [VW-1:0] ONE =
		{{(VW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	localparam logic OP_VALUE = 1'b0;
	localparam logic OP_DERIV = 1'b1;

	typedef struct packed {
		logic                 op;
		logic [NW-1:0]        order;
		logic [IW-1:0]        alpha;
		logic [IW-1:0]        beta;
		logic signed [XW-1:0] x;
		logic                 last_point;
	} in_t;

	typedef struct packed {
		logic signed [VW-1:0] value;
		logic                 overflow;
		logic                 last_point_res;
	} out_t;

	// classified work item between front and back
	typedef struct packed {
		logic                 direct;
		logic signed [VW-1:0] direct_value;
		logic                 deriv;
		logic [NW-1:0]        ne;
		logic [WW-1:0]        ae;
		logic [WW-1:0]        be;
		logic [KW-1:0]        k;
		logic signed [XW-1:0] x;
		logic                 last;
	} job_t;

	typedef struct packed {
		logic [AW-1:0] num;
		logic [VW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [VW-1:0] q;
		logic                 ovf;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/jpe_div.sv
// ----------------------------------------------------------------------------
// Jacobi divider
// Signed 128-bit by unsigned 64-bit division, four quotient bits per cycle,
// round to nearest with ties away from zero, saturate to 64 bits.
// A divisor of two skips the digit loop and takes a one-bit shift instead.
// ----------------------------------------------------------------------------
`default_nettype none

module jpe_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire jpe_pkg::div_req_t  req,
	output jpe_pkg::div_rsp_t       rsp
);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND, D_SAT} dstate_t;

	dstate_t                     state_q;
	logic [jpe_pkg::DCW-1:0]     cnt_q;
	logic [jpe_pkg::AW-1:0]      u_q;
	logic [jpe_pkg::AW-1:0]      q_q;
	logic [jpe_pkg::VW-1:0]      rem_q;
	logic [jpe_pkg::VW-1:0]      den_q;
	logic                        neg_q;

	logic [jpe_pkg::AW-1:0]      u_n;
	logic [jpe_pkg::AW-1:0]      q_n;
	logic [jpe_pkg::VW-1:0]      r_n;
	logic [jpe_pkg::VW:0]        r_w;
	logic                        ge;
	logic                        ovf_neg;
	logic                        ovf_pos;
	logic [jpe_pkg::AW-1:0]      mag_in;
	logic                        half;

	assign mag_in = req.num[jpe_pkg::AW-1] ? -req.num : req.num;
	assign half   = req.den == jpe_pkg::VW'(2);

	always_comb begin
		u_n = u_q;
		q_n = q_q;
		r_n = rem_q;
		r_w = '0;
		ge  = 1'b0;
		for (int t = 0; t < jpe_pkg::DIV_STEP; t++) begin
			r_w = {r_n, u_n[jpe_pkg::AW-1]};
			u_n = {u_n[jpe_pkg::AW-2:0], 1'b0};
			ge  = r_w >= {1'b0, den_q};
			q_n = {q_n[jpe_pkg::AW-2:0], ge};
			r_n = ge ? jpe_pkg::VW'(r_w - {1'b0, den_q}) : r_w[jpe_pkg::VW-1:0];
		end
	end

	assign ovf_neg = (q_q[jpe_pkg::AW-1:jpe_pkg::VW] != '0) ||
		(q_q[jpe_pkg::VW-1] && (q_q[jpe_pkg::VW-2:0] != '0));
	assign ovf_pos = q_q[jpe_pkg::AW-1:jpe_pkg::VW-1] != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			rsp     <= '0;
		end else begin
			rsp.done <= state_q == D_SAT;
			case (state_q)
				D_IDLE: begin
					if (go) begin
						cnt_q   <= '0;
						state_q <= half ? D_ROUND : D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == jpe_pkg::DCW'(jpe_pkg::DIV_CYCLES - 1)) begin
						state_q <= D_ROUND;
					end
				end
				D_ROUND: begin
					state_q <= D_SAT;
				end
				D_SAT: begin
					if (neg_q) begin
						rsp.ovf <= ovf_neg;
						rsp.q   <= ovf_neg ? {1'b1, {(jpe_pkg::VW-1){1'b0}}} :
							$signed(-q_q[jpe_pkg::VW-1:0]);
					end else begin
						rsp.ovf <= ovf_pos;
						rsp.q   <= ovf_pos ? {1'b0, {(jpe_pkg::VW-1){1'b1}}} :
							$signed(q_q[jpe_pkg::VW-1:0]);
					end
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && go) begin
			neg_q <= req.num[jpe_pkg::AW-1];
			u_q   <= mag_in;
			den_q <= req.den;
			if (half) begin
				q_q   <= mag_in >> 1;
				rem_q <= jpe_pkg::VW'(mag_in[0]);
			end else begin
				q_q   <= '0;
				rem_q <= '0;
			end
		end else if (state_q == D_RUN) begin
			u_q   <= u_n;
			q_q   <= q_n;
			rem_q <= r_n;
		end else if (state_q == D_ROUND) begin
			// round half away from zero on the magnitude
			if (rem_q >= den_q - rem_q) begin
				q_q <= q_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/jpe_front.sv
// ----------------------------------------------------------------------------
// Jacobi front end
// Registers an input beat, clamps order and weights, and classifies it into
// a direct result or a recurrence job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jpe_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire jpe_pkg::in_t   item,
	output logic                full,
	output logic                enq_valid,
	output jpe_pkg::job_t       enq_job,
	input  wire logic           enq_ready
);

	logic                   hold_q;
	jpe_pkg::in_t           item_q;
	logic [jpe_pkg::NW-1:0] n;
	logic [jpe_pkg::WW-1:0] a;
	logic [jpe_pkg::WW-1:0] b;

	assign full      = hold_q && !enq_ready;
	assign enq_valid = hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (push && !full) begin
			hold_q <= 1'b1;
		end else if (enq_ready) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_q <= item;
		end
	end

	always_comb begin
		n = (item_q.order > jpe_pkg::NW'(jpe_pkg::MAX_ORDER)) ?
			jpe_pkg::NW'(jpe_pkg::MAX_ORDER) : item_q.order;
		a = jpe_pkg::WW'(item_q.alpha);
		b = jpe_pkg::WW'(item_q.beta);
		if (a > jpe_pkg::WW'(jpe_pkg::MAX_WEIGHT)) begin
			a = jpe_pkg::WW'(jpe_pkg::MAX_WEIGHT);
		end
		if (b > jpe_pkg::WW'(jpe_pkg::MAX_WEIGHT)) begin
			b = jpe_pkg::WW'(jpe_pkg::MAX_WEIGHT);
		end

		enq_job              = '0;
		enq_job.deriv        = item_q.op;
		enq_job.ne           = n;
		enq_job.ae           = a;
		enq_job.be           = b;
		enq_job.k            = jpe_pkg::KW'(a) + jpe_pkg::KW'(b) + jpe_pkg::KW'(n) + 1'b1;
		enq_job.x            = item_q.x;
		enq_job.last         = item_q.last_point;

		if (item_q.op == jpe_pkg::OP_VALUE) begin
			if (n == '0) begin
				enq_job.direct       = 1'b1;
				enq_job.direct_value = jpe_pkg::ONE;
			end
		end else begin
			if (n == '0) begin
				enq_job.direct       = 1'b1;
				enq_job.direct_value = '0;
			end else if (n == jpe_pkg::NW'(1)) begin
				// (a+b+2)/2 in fixed point is exact
				enq_job.direct       = 1'b1;
				enq_job.direct_value = (jpe_pkg::VW'(a) + jpe_pkg::VW'(b) + 2'd2)
					<< (jpe_pkg::FRAC_BITS - 1);
			end else begin
				// derivative from the lower order with raised weights
				enq_job.ne = n - 1'b1;
				enq_job.ae = a + 1'b1;
				enq_job.be = b + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/jpe_queue.sv
// ----------------------------------------------------------------------------
// Jacobi job queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jpe_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           enq_valid,
	input  wire jpe_pkg::job_t  enq_job,
	output logic                enq_ready,
	output logic                deq_valid,
	output jpe_pkg::job_t       deq_job,
	input  wire logic           deq_ready
);

	jpe_pkg::job_t           mem_q [jpe_pkg::QDEPTH];
	logic [jpe_pkg::QAW-1:0] wp_q;
	logic [jpe_pkg::QAW-1:0] rp_q;
	logic [jpe_pkg::QCW-1:0] cnt_q;
	logic                    do_enq;
	logic                    do_deq;

	assign enq_ready = cnt_q != jpe_pkg::QCW'(jpe_pkg::QDEPTH);
	assign deq_valid = cnt_q != '0;
	assign deq_job   = mem_q[rp_q];
	assign do_enq    = enq_valid && enq_ready;
	assign do_deq    = deq_valid && deq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_enq) begin
				wp_q <= (wp_q == jpe_pkg::QAW'(jpe_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_deq) begin
				rp_q <= (rp_q == jpe_pkg::QAW'(jpe_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_enq && !do_deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_deq && !do_enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem_q[wp_q] <= enq_job;
		end
	end

endmodule

`default_nettype wire

>>> rtl/jpe_back.sv
// ----------------------------------------------------------------------------
// Jacobi back end
// Sequences the three-term recurrence: coefficient build, a 32x32 limb
// multiply-accumulate of A*B - C*D into 128 bits, then the shared divider.
// Holds the result register toward the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module jpe_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               deq_valid,
	input  wire jpe_pkg::job_t      deq_job,
	output logic                    deq_ready,
	output logic                    empty,
	input  wire logic               pop,
	output jpe_pkg::out_t           result,
	output logic                    div_go,
	output jpe_pkg::div_req_t       div_req,
	input  wire jpe_pkg::div_rsp_t  div_rsp
);

	localparam int MUL_STEPS = 8;   // two terms, two by two limbs each
	localparam int JW        = $clog2(MUL_STEPS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_COEF0, S_COEF1, S_COEF2, S_COEF3, S_MUL, S_DIV, S_DONE
	} state_t;

	state_t                        state_q;
	logic [jpe_pkg::NW-1:0]        i_q;
	logic [JW-1:0]                 j_q;
	logic                          scale_q;
	logic                          ovf_q;
	logic                          res_valid_q;

	logic                          deriv_q;
	logic [jpe_pkg::NW-1:0]        ne_q;
	logic [jpe_pkg::WW-1:0]        ae_q;
	logic [jpe_pkg::WW-1:0]        be_q;
	logic [jpe_pkg::KW-1:0]        k_q;
	logic signed [jpe_pkg::XW-1:0] x_q;
	logic                          last_q;
	logic signed [jpe_pkg::VW-1:0] cur_q;
	logic signed [jpe_pkg::VW-1:0] prev_q;
	logic signed [jpe_pkg::VW-1:0] fin_q;

	logic [jpe_pkg::CW-1:0]        s_q;
	logic [jpe_pkg::CW-1:0]        t1_q;
	logic [jpe_pkg::CW-1:0]        t3_q;
	logic [jpe_pkg::CW-1:0]        t4_q;
	logic signed [jpe_pkg::CW-1:0] d2_q;
	logic [jpe_pkg::CW-1:0]        c1_q;
	logic signed [jpe_pkg::CW-1:0] c2_q;
	logic [jpe_pkg::CW-1:0]        c3_q;
	logic [jpe_pkg::CW-1:0]        c4_q;
	logic signed [jpe_pkg::VW-1:0] cx_q;

	logic [jpe_pkg::VW-1:0]        ma_q;
	logic [jpe_pkg::VW-1:0]        mb_q;
	logic [jpe_pkg::VW-1:0]        mc_q;
	logic [jpe_pkg::VW-1:0]        md_q;
	logic                          neg0_q;
	logic                          neg1_q;
	logic [jpe_pkg::VW-1:0]        den_q;
	logic [jpe_pkg::AW-1:0]        acc_q;
	logic [2*jpe_pkg::LW-1:0]      pp_s1;
	logic [1:0]                    ppsh_s1;
	logic                          ppneg_s1;

	logic                          launch;
	logic signed [jpe_pkg::VW-1:0] la;
	logic signed [jpe_pkg::VW-1:0] lb;
	logic signed [jpe_pkg::VW-1:0] lc;
	logic signed [jpe_pkg::VW-1:0] ld;
	logic [jpe_pkg::VW-1:0]        lden;
	logic [jpe_pkg::NW-1:0]        i_next;
	logic                          eval_end;
	logic [jpe_pkg::VW-1:0]        opx;
	logic [jpe_pkg::VW-1:0]        opy;
	logic [jpe_pkg::LW-1:0]        lx;
	logic [jpe_pkg::LW-1:0]        ly;
	logic [jpe_pkg::AW-1:0]        pp_ext;
	logic signed [jpe_pkg::CW+jpe_pkg::XW:0] cx;
	logic [jpe_pkg::CW-1:0]        s_n;

	function automatic logic [jpe_pkg::VW-1:0] mag(input logic signed [jpe_pkg::VW-1:0] v);
		return v[jpe_pkg::VW-1] ? jpe_pkg::VW'(-v) : jpe_pkg::VW'(v);
	endfunction

	assign i_next   = i_q + 1'b1;
	assign eval_end = i_next == ne_q;
	assign empty    = !res_valid_q;
	assign div_req  = '{num: acc_q, den: den_q};

	assign deq_ready = (state_q == S_IDLE) && deq_valid &&
		(!deq_job.direct || !res_valid_q);

	// operand set for the next multiply-divide pass
	always_comb begin
		launch = 1'b0;
		la     = '0;
		lb     = '0;
		lc     = '0;
		ld     = '0;
		lden   = jpe_pkg::VW'(2);
		case (state_q)
			S_IDLE: begin
				if (deq_valid && !deq_job.direct) begin
					// first order: (a+b+2)x - (b-a)
					launch = 1'b1;
					la = jpe_pkg::VW'(deq_job.ae) + jpe_pkg::VW'(deq_job.be) + 2'd2;
					lb = {{(jpe_pkg::VW-jpe_pkg::XW){deq_job.x[jpe_pkg::XW-1]}}, deq_job.x};
					lc = jpe_pkg::VW'(deq_job.be) - jpe_pkg::VW'(deq_job.ae);
					ld = jpe_pkg::ONE;
				end
			end
			S_COEF3: begin
				launch = 1'b1;
				la   = (jpe_pkg::VW'(c2_q) <<< jpe_pkg::FRAC_BITS) + cx_q;
				lb   = cur_q;
				lc   = jpe_pkg::VW'(c4_q) << jpe_pkg::FRAC_BITS;
				ld   = prev_q;
				lden = jpe_pkg::VW'(c1_q) << jpe_pkg::FRAC_BITS;
			end
			S_DIV: begin
				if (div_rsp.done && !scale_q && eval_end && deriv_q) begin
					launch = 1'b1;
					la = div_rsp.q;
					lb = jpe_pkg::VW'(k_q);
				end
			end
			default: launch = 1'b0;
		endcase
	end

	always_comb begin
		opx    = j_q[2] ? mc_q : ma_q;
		opy    = j_q[2] ? md_q : mb_q;
		lx     = j_q[1] ? opx[2*jpe_pkg::LW-1:jpe_pkg::LW] : opx[jpe_pkg::LW-1:0];
		ly     = j_q[0] ? opy[2*jpe_pkg::LW-1:jpe_pkg::LW] : opy[jpe_pkg::LW-1:0];
		pp_ext = jpe_pkg::AW'(pp_s1) << (ppsh_s1 * jpe_pkg::LW);
		cx     = $signed({1'b0, c3_q}) * x_q;
		s_n    = jpe_pkg::CW'({i_q, 1'b0}) + jpe_pkg::CW'(ae_q) + jpe_pkg::CW'(be_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			scale_q     <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			div_go      <= 1'b0;
			result      <= '0;
		end else begin
			div_go <= (state_q == S_MUL) && (j_q == JW'(MUL_STEPS));
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (deq_ready && deq_job.direct) begin
						result      <= '{deq_job.direct_value, 1'b0, deq_job.last};
						res_valid_q <= 1'b1;
					end else if (launch) begin
						i_q     <= '0;
						j_q     <= '0;
						scale_q <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_COEF0: state_q <= S_COEF1;
				S_COEF1: state_q <= S_COEF2;
				S_COEF2: state_q <= S_COEF3;
				S_COEF3: begin
					j_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					j_q <= j_q + 1'b1;
					if (j_q == JW'(MUL_STEPS)) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						ovf_q <= ovf_q | div_rsp.ovf;
						if (scale_q || (eval_end && !deriv_q)) begin
							state_q <= S_DONE;
						end else if (eval_end) begin
							scale_q <= 1'b1;
							j_q     <= '0;
							state_q <= S_MUL;
						end else begin
							i_q     <= i_next;
							state_q <= S_COEF0;
						end
					end
				end
				S_DONE: begin
					if (!res_valid_q) begin
						result      <= '{fin_q, ovf_q, last_q};
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && launch) begin
			deriv_q <= deq_job.deriv;
			ne_q    <= deq_job.ne;
			ae_q    <= deq_job.ae;
			be_q    <= deq_job.be;
			k_q     <= deq_job.k;
			x_q     <= deq_job.x;
			last_q  <= deq_job.last;
			cur_q   <= jpe_pkg::ONE;
		end
		if (state_q == S_DIV && div_rsp.done) begin
			fin_q <= div_rsp.q;
			if (!scale_q) begin
				prev_q <= cur_q;
				cur_q  <= div_rsp.q;
			end
		end

		// recurrence coefficients for index i
		if (state_q == S_COEF0) begin
			s_q  <= s_n;
			t1_q <= jpe_pkg::CW'(jpe_pkg::CW'(i_q) + 1'b1) *
				(jpe_pkg::CW'(i_q) + jpe_pkg::CW'(ae_q) + jpe_pkg::CW'(be_q) + 1'b1);
			t3_q <= s_n * (s_n + 1'b1);
			t4_q <= (jpe_pkg::CW'(i_q) + jpe_pkg::CW'(ae_q)) *
				(jpe_pkg::CW'(i_q) + jpe_pkg::CW'(be_q));
			d2_q <= $signed(jpe_pkg::CW'(ae_q) * jpe_pkg::CW'(ae_q)) -
				$signed(jpe_pkg::CW'(be_q) * jpe_pkg::CW'(be_q));
		end
		if (state_q == S_COEF1) begin
			c1_q <= (t1_q * s_q) << 1;
			c2_q <= $signed(s_q + 1'b1) * d2_q;
			c3_q <= t3_q * (s_q + 2'd2);
			c4_q <= (t4_q * (s_q + 2'd2)) << 1;
		end
		if (state_q == S_COEF2) begin
			cx_q <= jpe_pkg::VW'(cx);
		end

		if (launch) begin
			ma_q   <= mag(la);
			mb_q   <= mag(lb);
			mc_q   <= mag(lc);
			md_q   <= mag(ld);
			neg0_q <= la[jpe_pkg::VW-1] ^ lb[jpe_pkg::VW-1];
			// second term is subtracted
			neg1_q <= !(lc[jpe_pkg::VW-1] ^ ld[jpe_pkg::VW-1]);
			den_q  <= lden;
			acc_q  <= '0;
		end else if (state_q == S_MUL) begin
			if (j_q < JW'(MUL_STEPS)) begin
				pp_s1    <= lx * ly;
				ppsh_s1  <= 2'(j_q[1]) + 2'(j_q[0]);
				ppneg_s1 <= j_q[2] ? neg1_q : neg0_q;
			end
			if (j_q != '0) begin
				acc_q <= ppneg_s1 ? acc_q - pp_ext : acc_q + pp_ext;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/jacobi_polynomial_evaluator.sv
// Zero-order items and first-order derivative items are direct and skip the recurrence. Value
// items of order m take a first-order pass, then one recurrence step per further order; a
// derivative evaluates order n-1 with raised weights and adds a halving pass. Each order step
// runs coefficient build, multiply and divide; halving passes skip the divider's digit loop.
// The back end works one item at a time; further items wait in the front register and queue.
// Reset (arst_n low, asynchronous) empties the queue, the result register and all sequencers.
// ----------------------------------------------------------------------------
// Jacobi polynomial evaluator
// Evaluates P_n^(a,b)(x) or its derivative in signed Q33.30 fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_polynomial_evaluator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire jpe_pkg::in_t   item,
	output logic                empty,
	input  wire logic           pop,
	output jpe_pkg::out_t       result
);

	logic               enq_valid;
	logic               enq_ready;
	jpe_pkg::job_t      enq_job;
	logic               deq_valid;
	logic               deq_ready;
	jpe_pkg::job_t      deq_job;
	logic               div_go;
	jpe_pkg::div_req_t  div_req;
	jpe_pkg::div_rsp_t  div_rsp;

	jpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.enq_valid (enq_valid),
		.enq_job   (enq_job),
		.enq_ready (enq_ready)
	);

	jpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq_valid (enq_valid),
		.enq_job   (enq_job),
		.enq_ready (enq_ready),
		.deq_valid (deq_valid),
		.deq_job   (deq_job),
		.deq_ready (deq_ready)
	);

	jpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (deq_valid),
		.deq_job   (deq_job),
		.deq_ready (deq_ready),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.div_go    (div_go),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	jpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

>>> rtl/jpe_checker.sv
// ----------------------------------------------------------------------------
// Jacobi evaluator port checker
// Tracks beats in flight and checks the evaluator ports against that count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jacobi_polynomial_evaluator_macros.svh"

module jpe_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire logic           full,
	input  wire logic           empty,
	input  wire logic           pop,
	input  wire jpe_pkg::out_t  result
);

	// front register, queue, back end and result register
	localparam logic [2:0] MAX_INFLIGHT = 3'd5;

	logic [2:0] cnt_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = push && !full;
	assign out_beat = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_beat && !out_beat) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	`JPE_CHECK(a_result_has_item, !empty |-> cnt_q != 3'd0)
	`JPE_CHECK(a_not_full_when_drained, cnt_q == 3'd0 |-> !full)
	`JPE_CHECK(a_inflight_bounded, cnt_q <= MAX_INFLIGHT)
	`JPE_CHECK_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result))

endmodule

bind jacobi_polynomial_evaluator jpe_checker u_chk (.*);

`default_nettype wire

>>> bench/tb_jacobi_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// Jacobi polynomial evaluator testbench
// Drives points through the push/full side and pops results at random.
// Each result is checked field by field against an in-bench evaluation of
// the three-term recurrence with 128-bit products and rounded division.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_jacobi_polynomial_evaluator;

	class jacobi_ledger;
		jpe_pkg::out_t due_results[$];
		int            errors;

		// Signed wide numerator over a positive divisor, round half away, clamp.
		function automatic logic signed [jpe_pkg::VW-1:0] round_div(
				logic signed [jpe_pkg::AW-1:0] num, logic [jpe_pkg::VW-1:0] den,
				inout bit ovf);
			logic [jpe_pkg::AW-1:0] mag_n, quo, rem;
			bit neg;
			neg = num[jpe_pkg::AW-1];
			mag_n = neg ? -num : num;
			quo = mag_n / den;
			rem = mag_n % den;
			if (rem >= {64'd0, den} - rem) quo = quo + 1;
			if (neg) begin
				if (quo > 128'h8000_0000_0000_0000) begin
					ovf = 1;
					return 64'sh8000_0000_0000_0000;
				end
				return -quo[jpe_pkg::VW-1:0];
			end
			if (quo > 128'h7fff_ffff_ffff_ffff) begin
				ovf = 1;
				return 64'sh7fff_ffff_ffff_ffff;
			end
			return quo[jpe_pkg::VW-1:0];
		endfunction

		function automatic logic signed [jpe_pkg::AW-1:0] wide_mul(longint a, longint b);
			logic signed [jpe_pkg::AW-1:0] wa, wb;
			wa = a;
			wb = b;
			return wa * wb;
		endfunction

		function automatic longint jacobi_at(longint n, longint a, longint b, longint x,
				inout bit ovf);
			longint one, prev, cur, nxt, s, c1, c2, c3, c4, coef;
			logic signed [jpe_pkg::AW-1:0] num;
			one = 64'sd1 <<< jpe_pkg::FRAC_BITS;
			if (n == 0) return one;
			prev = one;
			cur = round_div(wide_mul(a - b, one) + wide_mul(a + b + 2, x), 64'd2, ovf);
			for (longint i = 1; i < n; i++) begin
				s = 2 * i + a + b;
				c1 = 2 * (i + 1) * (i + a + b + 1) * s;
				c2 = (s + 1) * (a * a - b * b);
				c3 = s * (s + 1) * (s + 2);
				c4 = 2 * (i + a) * (i + b) * (s + 2);
				coef = c2 * one + c3 * x;
				num = wide_mul(coef, cur) - wide_mul(c4 * one, prev);
				nxt = round_div(num, c1 * one, ovf);
				prev = cur;
				cur = nxt;
			end
			return cur;
		endfunction

		function void note(jpe_pkg::in_t it);
			jpe_pkg::out_t r;
			bit ovf;
			longint n, a, b, x, p;
			ovf = 0;
			n = longint'(it.order);
			a = longint'(it.alpha);
			b = longint'(it.beta);
			x = longint'(it.x);
			if (it.op == jpe_pkg::OP_VALUE) r.value = jacobi_at(n, a, b, x, ovf);
			else if (n == 0) r.value = 0;
			else if (n == 1)
				r.value = round_div(wide_mul(a + b + 2, 64'sd1 <<< jpe_pkg::FRAC_BITS),
					64'd2, ovf);
			else begin
				p = jacobi_at(n - 1, a + 1, b + 1, x, ovf);
				r.value = round_div(wide_mul(p, a + b + n + 1), 64'd2, ovf);
			end
			r.overflow = ovf;
			r.last_point_res = it.last_point;
			due_results.push_back(r);
		endfunction

		function void check(jpe_pkg::out_t got);
			jpe_pkg::out_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result beat value=%0d", $time, got.value);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.value !== want.value) begin
				$display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$display("%0t: overflow expected %0b actual %0b", $time,
					want.overflow, got.overflow);
				errors++;
			end
			if (got.last_point_res !== want.last_point_res) begin
				$display("%0t: last_point_res expected %0b actual %0b", $time,
					want.last_point_res, got.last_point_res);
				errors++;
			end
		endfunction
	endclass

	logic          clk = 0;
	logic          arst_n = 0;
	logic          push = 0;
	logic          pop = 0;
	logic          full, empty;
	jpe_pkg::in_t  item = '0;
	jpe_pkg::out_t result;
	bit            calm = 0;
	jacobi_ledger  ledger = new();

	jacobi_polynomial_evaluator dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		pop <= calm || ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) ledger.check(result);
	end

	task automatic send(jpe_pkg::in_t it);
		while (!calm && $urandom_range(99) < 17) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		item <= it;
		do @(posedge clk); while (full);
		ledger.note(it);
		@(negedge clk);
	endtask

	task automatic send_fields(int op, int n, int a, int b,
			logic signed [jpe_pkg::XW-1:0] x, int lp);
		jpe_pkg::in_t it;
		it.op = (op != 0) ? jpe_pkg::OP_DERIV : jpe_pkg::OP_VALUE;
		it.order = jpe_pkg::NW'(n);
		it.alpha = jpe_pkg::IW'(a);
		it.beta = jpe_pkg::IW'(b);
		it.x = x;
		it.last_point = (lp != 0);
		send(it);
	endtask

	initial begin
		logic signed [jpe_pkg::XW-1:0] px;
		logic signed [jpe_pkg::XW-1:0] one_x;
		int n;
		one_x = 32'sh4000_0000;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// extremes of point, order and weights, both ops
		for (int op = 0; op < 2; op++) begin
			send_fields(op, 0, 0, 0, 0, 0);
			send_fields(op, 1, 15, 0, one_x, 0);
			send_fields(op, 1, 0, 15, -one_x, 1);
			send_fields(op, 2, 3, 5, 32'sh2000_0000, 0);
			send_fields(op, 15, 15, 15, one_x, 0);
			send_fields(op, 15, 15, 15, -one_x, 0);
			send_fields(op, 15, 0, 0, 0, 0);
			send_fields(op, 15, 15, 0, -one_x, 1);
			send_fields(op, 15, 0, 15, 32'sh0000_0001, 0);
			send_fields(op, 7, 15, 15, 32'shffff_ffff, 1);
		end

		for (int k = 0; k < 1000; k++) begin
			calm = (k >= 400 && k < 550);
			px = $urandom_range(32'h8000_0000, 0);
			px = px - one_x;
			case ($urandom_range(9))
				0: px = one_x;
				1: px = -one_x;
				default: ;
			endcase
			n = ($urandom_range(3) == 0) ? $urandom_range(15, 12) : $urandom_range(15);
			send_fields($urandom_range(1), n, $urandom_range(15), $urandom_range(15), px,
				$urandom_range(1));
		end
		push <= 0;
		calm = 0;

		while (ledger.due_results.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (ledger.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
